// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; clk_i and rst_ni must be in scope where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/lseq_pkg.sv =====
package lseq_pkg;

  typedef enum logic [2:0] {
    PROG_OFF     = 3'd0,
    PROG_NOMINAL = 3'd1,
    PROG_MAX     = 3'd2,
    PROG_BRAKE   = 3'd3,
    PROG_RAMP    = 3'd4,
    PROG_BLINK   = 3'd5,
    PROG_MARKER  = 3'd6
  } prog_e;

  // Ramp uses START/UP/DOWN; blink uses START/UP (UP = running).
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_UP    = 2'd1,
    PH_DOWN  = 2'd2,
    PH_SPARE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CFG_MAX_LEVEL      = 3'd0,
    CFG_BRAKE_LEVEL    = 3'd1,
    CFG_MARK_LEVEL     = 3'd2,
    CFG_SLOW_LOW_LEVEL = 3'd3,
    CFG_MIN_LEVEL      = 3'd4,
    CFG_STEP_SIZE      = 3'd5,
    CFG_DONE_THRESHOLD = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } seq_state_e;

  localparam logic [7:0] RST_MAX_LEVEL      = 8'd250;
  localparam logic [7:0] RST_BRAKE_LEVEL    = 8'd150;
  localparam logic [7:0] RST_MARK_LEVEL     = 8'd20;
  localparam logic [7:0] RST_SLOW_LOW_LEVEL = 8'd50;
  localparam logic [7:0] RST_MIN_LEVEL      = 8'd10;
  localparam logic [4:0] RST_STEP_SIZE      = 5'd1;
  localparam logic [2:0] RST_DONE_THRESHOLD = 3'd5;

  typedef struct packed {
    logic       op;
    logic [2:0] channel;
    logic [2:0] program_req;
    logic [7:0] speed;
    logic [7:0] nominal;
    logic       load_level;
    logic [7:0] new_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_channel;
    logic [9:0] duty;
    logic       channel_done;
    logic       last;
    logic       all_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] max_level;
    logic [7:0] brake_level;
    logic [7:0] mark_level;
    logic [7:0] slow_low_level;
    logic [7:0] min_level;
    logic [4:0] step_size;
    logic [2:0] done_threshold;
  } cfg_t;

  typedef struct packed {
    logic [2:0] prog;
    logic [7:0] level;
    logic [7:0] step_period;
    logic [7:0] nominal_level;
    phase_e     phase;
    logic [7:0] tick_count;
  } chan_state_t;

  typedef struct packed {
    logic idle;
    logic calc;
    logic emit;
    logic last;
  } seq_t;

endpackage

// ===== hw/rtl/lseq_cfg_regs.sv =====
module lseq_cfg_regs
  import lseq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_level      <= RST_MAX_LEVEL;
      cfg_q.brake_level    <= RST_BRAKE_LEVEL;
      cfg_q.mark_level     <= RST_MARK_LEVEL;
      cfg_q.slow_low_level <= RST_SLOW_LOW_LEVEL;
      cfg_q.min_level      <= RST_MIN_LEVEL;
      cfg_q.step_size      <= RST_STEP_SIZE;
      cfg_q.done_threshold <= RST_DONE_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_LEVEL:      cfg_q.max_level      <= cfg_wdata_i;
        CFG_BRAKE_LEVEL:    cfg_q.brake_level    <= cfg_wdata_i;
        CFG_MARK_LEVEL:     cfg_q.mark_level     <= cfg_wdata_i;
        CFG_SLOW_LOW_LEVEL: cfg_q.slow_low_level <= cfg_wdata_i;
        CFG_MIN_LEVEL:      cfg_q.min_level      <= cfg_wdata_i;
        CFG_STEP_SIZE:      cfg_q.step_size      <= cfg_wdata_i[4:0];
        CFG_DONE_THRESHOLD: cfg_q.done_threshold <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/lseq_chan_store.sv =====
module lseq_chan_store
  import lseq_pkg::*;
#(
  parameter int CHANNELS = 6,
  parameter int CH_W     = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [CH_W-1:0]   waddr_i,
  input  chan_state_t       wdata_i,
  input  logic [CH_W-1:0]   raddr_i,
  output chan_state_t       rdata_o
);

  chan_state_t chan_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_q[i] <= '0;
      end
    end else if (we_i) begin
      chan_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = chan_q[raddr_i];

endmodule

// ===== hw/rtl/lseq_step_unit.sv =====
module lseq_step_unit
  import lseq_pkg::*;
(
  input  chan_state_t st_i,
  input  cfg_t        cfg_i,
  output chan_state_t st_o,
  output logic        done_o
);

  logic [7:0] tick_inc;
  logic       elapsed;
  logic [7:0] tick_next;
  logic [8:0] up_sum;
  logic [7:0] up_level;
  logic [7:0] down_level;
  logic [7:0] step8;

  assign step8     = {3'b000, cfg_i.step_size};
  assign tick_inc  = st_i.tick_count + 8'd1;
  assign elapsed   = tick_inc > st_i.step_period;
  assign tick_next = elapsed ? 8'd0 : tick_inc;
  assign up_sum    = {1'b0, st_i.level} + {1'b0, step8};

  always_comb begin
    up_level = st_i.level;
    if (elapsed) begin
      up_level = up_sum[8] ? 8'hff : up_sum[7:0];
    end
    down_level = st_i.level;
    if (elapsed) begin
      down_level = (st_i.level > step8) ? (st_i.level - step8) : 8'd0;
    end
  end

  always_comb begin
    st_o   = st_i;
    done_o = 1'b0;
    unique case (prog_e'(st_i.prog))
      PROG_OFF, PROG_NOMINAL, PROG_MAX, PROG_MARKER: begin
        done_o           = 1'b1;
        st_o.step_period = '0;
        st_o.phase       = PH_START;
        st_o.tick_count  = '0;
        case (prog_e'(st_i.prog))
          PROG_NOMINAL: st_o.level = st_i.nominal_level;
          PROG_MAX:     st_o.level = cfg_i.max_level;
          PROG_MARKER:  st_o.level = cfg_i.mark_level;
          default:      st_o.level = '0;
        endcase
      end
      PROG_BRAKE: begin
        done_o     = 1'b1;
        st_o.level = cfg_i.brake_level;
      end
      PROG_RAMP: begin
        case (st_i.phase)
          PH_START: begin
            st_o.tick_count = '0;
            st_o.phase      = PH_UP;
          end
          PH_UP: begin
            done_o = 1'b1;
            if (up_level > cfg_i.max_level) begin
              st_o.level      = cfg_i.max_level;
              st_o.phase      = PH_DOWN;
              st_o.tick_count = '0;
            end else begin
              st_o.level      = up_level;
              st_o.tick_count = tick_next;
            end
          end
          PH_DOWN: begin
            done_o = 1'b1;
            if (st_i.nominal_level != cfg_i.max_level &&
                down_level <= cfg_i.slow_low_level) begin
              st_o.level      = cfg_i.slow_low_level;
              st_o.phase      = PH_UP;
              st_o.tick_count = '0;
            end else if (st_i.nominal_level == cfg_i.max_level &&
                         down_level <= cfg_i.min_level) begin
              st_o.level      = cfg_i.min_level;
              st_o.phase      = PH_UP;
              st_o.tick_count = '0;
            end else begin
              st_o.level      = down_level;
              st_o.tick_count = tick_next;
            end
          end
          default: st_o.phase = PH_START;
        endcase
      end
      PROG_BLINK: begin
        case (st_i.phase)
          PH_START: begin
            st_o.tick_count = '0;
            st_o.phase      = PH_UP;
          end
          PH_UP: begin
            done_o          = 1'b1;
            st_o.tick_count = tick_next;
            if (elapsed) begin
              st_o.level = (st_i.level == cfg_i.max_level) ? 8'd0 : cfg_i.max_level;
            end
          end
          default: st_o.phase = PH_START;
        endcase
      end
      default: ;  // undefined program: hold, busy
    endcase
  end

endmodule

// ===== hw/rtl/lseq_ctrl.sv =====
`include "assert_macros.svh"

module lseq_ctrl
  import lseq_pkg::*;
#(
  parameter int CHANNELS = 6,
  parameter int CH_W     = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  input  logic            out_stall_i,
  input  logic            done_i,
  input  logic [2:0]      thr_i,
  output logic [CH_W-1:0] ch_o,
  output seq_t            seq_o,
  output logic            all_done_o
);

  localparam int FIN_W = ($clog2(CHANNELS + 1) > 3) ? $clog2(CHANNELS + 1) : 3;

  seq_state_e       state_q, state_d;
  logic [CH_W-1:0]  ch_q, ch_d;
  logic [FIN_W-1:0] fin_q, fin_d;
  logic [FIN_W-1:0] fin_new;
  logic             last;

  assign last       = (ch_q == CH_W'(CHANNELS - 1));
  assign fin_new    = fin_q + FIN_W'(done_i);
  assign all_done_o = last && (fin_new >= FIN_W'(thr_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      fin_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    fin_d      = fin_q;
    seq_o      = '0;
    seq_o.last = last;
    unique case (state_q)
      ST_IDLE: begin
        seq_o.idle = 1'b1;
        if (in_valid_i && !in_op_i) begin
          state_d = ST_CALC;
          ch_d    = '0;
          fin_d   = '0;
        end
      end
      ST_CALC: begin
        seq_o.calc = 1'b1;
        fin_d      = fin_new;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        seq_o.emit = 1'b1;
        if (!out_stall_i) begin
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + CH_W'(1);
            state_d = ST_CALC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ch_o = ch_q;

  `ASSERT_CHK(a_ch_range, ch_q <= CH_W'(CHANNELS - 1), "channel counter out of range")
  `ASSERT_CHK(a_emit_follows_calc, (state_q == ST_EMIT) |-> ($past(state_q) == ST_CALC || $past(state_q) == ST_EMIT), "result shown without a calc step")
  `ASSERT_CHK(a_last_to_idle, (state_q == ST_EMIT && !out_stall_i && last) |=> (state_q == ST_IDLE), "tick did not end after last channel")
  `ASSERT_CHK(a_tick_start, (state_q == ST_IDLE && in_valid_i && !in_op_i) |=> (state_q == ST_CALC && ch_q == '0), "tick did not start at channel zero")

endmodule

// ===== hw/rtl/led_effect_sequencer_core.sv =====
// LED effect sequencer. A set transfer (op=1) rewrites one channel's program, speed,
// nominal level and optionally its current level in the cycle it is accepted; it
// yields no result and the block is ready again on the next cycle. A tick transfer
// (op=0) walks the channels 0..CHANNELS-1 through one shared update unit: each channel
// is first updated, then its result is presented and held while out_stall_i is high;
// in_stall_o stays high until the last result of the tick has been taken. Duty is
// level times four; all_done is valid on last only.
`include "assert_macros.svh"

module led_effect_sequencer_core
  import lseq_pkg::*;
#(
  parameter int CHANNELS = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t            cfg;
  seq_t            seq;
  logic [CH_W-1:0] ch;
  logic [CH_W-1:0] set_addr;
  logic [CH_W-1:0] raddr;
  logic [CH_W-1:0] waddr;
  logic            set_we;
  logic            we;
  chan_state_t     rd_st;
  chan_state_t     set_st;
  chan_state_t     unit_st;
  chan_state_t     wdata;
  logic            done;
  logic            all_done;
  out_item_t       out_q;

  lseq_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  lseq_ctrl #(
    .CHANNELS(CHANNELS),
    .CH_W    (CH_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .out_stall_i(out_stall_i),
    .done_i     (done),
    .thr_i      (cfg.done_threshold),
    .ch_o       (ch),
    .seq_o      (seq),
    .all_done_o (all_done)
  );

  assign set_addr = CH_W'(in_data_i.channel);
  assign set_we   = in_valid_i && seq.idle && in_data_i.op &&
                    (32'(in_data_i.channel) < CHANNELS);
  assign raddr    = seq.idle ? set_addr : ch;

  always_comb begin
    set_st               = rd_st;
    set_st.prog          = in_data_i.program_req;
    set_st.step_period   = in_data_i.speed;
    set_st.nominal_level = in_data_i.nominal;
    if (in_data_i.load_level) begin
      set_st.level = in_data_i.new_level;
    end
  end

  assign we    = set_we || seq.calc;
  assign waddr = seq.calc ? ch : set_addr;
  assign wdata = seq.calc ? unit_st : set_st;

  lseq_chan_store #(
    .CHANNELS(CHANNELS),
    .CH_W    (CH_W)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_st)
  );

  lseq_step_unit u_unit (
    .st_i  (rd_st),
    .cfg_i (cfg),
    .st_o  (unit_st),
    .done_o(done)
  );

  always_ff @(posedge clk_i) begin
    if (seq.calc) begin
      out_q.out_channel  <= 3'(ch);
      out_q.duty         <= {unit_st.level, 2'b00};
      out_q.channel_done <= done;
      out_q.last         <= seq.last;
      out_q.all_done     <= all_done;
    end
  end

  assign in_stall_o  = !seq.idle;
  assign out_valid_o = seq.emit;
  assign out_data_o  = out_q;

  `ASSERT_NEVER(a_busy_while_emit, out_valid_o && !in_stall_o, "input taken while a result waits")
  `ASSERT_CHK(a_all_done_on_last, (out_valid_o && out_data_o.all_done) |-> out_data_o.last, "all_done outside last result")

endmodule

// ===== verif/led_effect_sequencer_duty_checker.sv =====
`timescale 1ns / 100ps

module led_effect_sequencer_duty_checker
  import lseq_pkg::*;
#(
  parameter int CHANNELS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_item_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_item_t  out_data_i,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o
);

  cfg_t       regs;
  logic [2:0] ch_prog    [CHANNELS];
  logic [7:0] ch_level   [CHANNELS];
  logic [7:0] ch_period  [CHANNELS];
  logic [7:0] ch_nominal [CHANNELS];
  phase_e     ch_phase   [CHANNELS];
  logic [7:0] ch_ticks   [CHANNELS];
  out_item_t  duty_expect_q[$];
  int         fails = 0;

  function automatic void clear_state();
    regs.max_level      = RST_MAX_LEVEL;
    regs.brake_level    = RST_BRAKE_LEVEL;
    regs.mark_level     = RST_MARK_LEVEL;
    regs.slow_low_level = RST_SLOW_LOW_LEVEL;
    regs.min_level      = RST_MIN_LEVEL;
    regs.step_size      = RST_STEP_SIZE;
    regs.done_threshold = RST_DONE_THRESHOLD;
    for (int c = 0; c < CHANNELS; c++) begin
      ch_prog[c]    = PROG_OFF;
      ch_level[c]   = '0;
      ch_period[c]  = '0;
      ch_nominal[c] = '0;
      ch_phase[c]   = PH_START;
      ch_ticks[c]   = '0;
    end
    duty_expect_q.delete();
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [7:0] value);
    case (idx)
      CFG_MAX_LEVEL:      regs.max_level      = value;
      CFG_BRAKE_LEVEL:    regs.brake_level    = value;
      CFG_MARK_LEVEL:     regs.mark_level     = value;
      CFG_SLOW_LOW_LEVEL: regs.slow_low_level = value;
      CFG_MIN_LEVEL:      regs.min_level      = value;
      CFG_STEP_SIZE:      regs.step_size      = value[4:0];
      CFG_DONE_THRESHOLD: regs.done_threshold = value[2:0];
      default: ;
    endcase
  endfunction

  function automatic void apply_set(in_item_t it);
    if (it.channel < CHANNELS) begin
      ch_prog[it.channel]    = it.program_req;
      ch_period[it.channel]  = it.speed;
      ch_nominal[it.channel] = it.nominal;
      if (it.load_level) ch_level[it.channel] = it.new_level;
    end
  endfunction

  function automatic logic period_done(int c);
    logic fire;
    fire = 1'b0;
    ch_ticks[c] = ch_ticks[c] + 8'd1;
    if (ch_ticks[c] > ch_period[c]) begin
      ch_ticks[c] = '0;
      fire = 1'b1;
    end
    return fire;
  endfunction

  function automatic logic hold_level(int c, logic [7:0] v);
    ch_level[c]  = v;
    ch_period[c] = '0;
    ch_phase[c]  = PH_START;
    ch_ticks[c]  = '0;
    return 1'b1;
  endfunction

  function automatic logic step_ramp(int c);
    logic       done;
    logic [8:0] sum;
    done = 1'b0;
    case (ch_phase[c])
      PH_START: begin
        ch_ticks[c] = '0;
        ch_phase[c] = PH_UP;
      end
      PH_UP: begin
        if (period_done(c)) begin
          sum = {1'b0, ch_level[c]} + {4'd0, regs.step_size};
          ch_level[c] = sum[8] ? 8'hFF : sum[7:0];
        end
        if (ch_level[c] > regs.max_level) begin
          ch_level[c] = regs.max_level;
          ch_phase[c] = PH_DOWN;
          ch_ticks[c] = '0;
        end
        done = 1'b1;
      end
      PH_DOWN: begin
        if (period_done(c))
          ch_level[c] = (ch_level[c] > regs.step_size) ? ch_level[c] - regs.step_size : 8'd0;
        if (ch_nominal[c] != regs.max_level && ch_level[c] <= regs.slow_low_level) begin
          ch_level[c] = regs.slow_low_level;
          ch_phase[c] = PH_UP;
          ch_ticks[c] = '0;
        end else if (ch_nominal[c] == regs.max_level && ch_level[c] <= regs.min_level) begin
          ch_level[c] = regs.min_level;
          ch_phase[c] = PH_UP;
          ch_ticks[c] = '0;
        end
        done = 1'b1;
      end
      default: ch_phase[c] = PH_START;
    endcase
    return done;
  endfunction

  function automatic logic step_blink(int c);
    logic done;
    done = 1'b0;
    case (ch_phase[c])
      PH_START: begin
        ch_ticks[c] = '0;
        ch_phase[c] = PH_UP;
      end
      PH_UP: begin
        if (period_done(c))
          ch_level[c] = (ch_level[c] == regs.max_level) ? 8'd0 : regs.max_level;
        done = 1'b1;
      end
      default: ch_phase[c] = PH_START;
    endcase
    return done;
  endfunction

  function automatic logic step_channel(int c);
    logic done;
    done = 1'b0;
    case (ch_prog[c])
      PROG_OFF:     done = hold_level(c, 8'd0);
      PROG_NOMINAL: done = hold_level(c, ch_nominal[c]);
      PROG_MAX:     done = hold_level(c, regs.max_level);
      PROG_BRAKE: begin
        ch_level[c] = regs.brake_level;
        done = 1'b1;
      end
      PROG_RAMP:    done = step_ramp(c);
      PROG_BLINK:   done = step_blink(c);
      PROG_MARKER:  done = hold_level(c, regs.mark_level);
      default:      done = 1'b0;
    endcase
    return done;
  endfunction

  function automatic void predict_tick();
    int        finished;
    out_item_t r;
    finished = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      r.channel_done = step_channel(c);
      if (r.channel_done) finished++;
      r.out_channel = 3'(c);
      r.duty        = {ch_level[c], 2'b00};
      r.last        = (c == CHANNELS - 1);
      r.all_done    = r.last && (finished >= regs.done_threshold);
      duty_expect_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function automatic void compare_result(out_item_t got);
    out_item_t want;
    if (duty_expect_q.size() == 0) begin
      $error("result with nothing expected: out_channel %0d duty %0d",
             got.out_channel, got.duty);
      fails++;
    end else begin
      want = duty_expect_q.pop_front();
      check_field("out_channel", want.out_channel, got.out_channel);
      check_field("duty", want.duty, got.duty);
      check_field("channel_done", want.channel_done, got.channel_done);
      check_field("last", want.last, got.last);
      check_field("all_done", want.all_done, got.all_done);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.op) apply_set(in_data_i);
        else predict_tick();
      end
    end
    fail_count_o <= fails;
    pending_o    <= duty_expect_q.size();
  end

endmodule

// ===== verif/led_effect_sequencer_core_test.sv =====
`timescale 1ns / 100ps

module led_effect_sequencer_core_test
  import lseq_pkg::*;
;

  localparam int CHANNELS        = 6;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int SETTLE_CYCLES   = 2 * CHANNELS + 4;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 50;

  localparam logic       OP_TICK        = 1'b0;
  localparam logic       OP_SET         = 1'b1;
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [2:0] PROG_UNDEFINED = 3'd7;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_idx   = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_data;
  int         fail_count;
  int         pending;
  int         burst_left = 0;
  int         stall_left = 0;
  logic [7:0] cur_max    = RST_MAX_LEVEL;

  always #5 clk = ~clk;

  led_effect_sequencer_core #(.CHANNELS(CHANNELS)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  led_effect_sequencer_duty_checker #(.CHANNELS(CHANNELS)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: short stalls, short free runs, and now and then a long free run
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 7);
        end
        3: begin
          out_stall <= 1'b0;
          stall_left = $urandom_range(30, 60);
        end
        default: begin
          out_stall <= 1'b0;
          stall_left = $urandom_range(0, 4);
        end
      endcase
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("led_effect_sequencer_core test failed");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data  <= in_item_t'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tick();
    in_item_t it;
    it    = in_item_t'($urandom);
    it.op = OP_TICK;
    send_item(it);
  endtask

  task automatic send_set(input logic [2:0] ch, input logic [2:0] prog, input logic [7:0] speed,
                          input logic [7:0] nominal, input logic load, input logic [7:0] lvl);
    in_item_t it;
    it.op          = OP_SET;
    it.channel     = ch;
    it.program_req = prog;
    it.speed       = speed;
    it.nominal     = nominal;
    it.load_level  = load;
    it.new_level   = lvl;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [7:0] max_lvl, input logic [7:0] brake,
                               input logic [7:0] mark, input logic [7:0] slow_low,
                               input logic [7:0] min_lvl, input logic [7:0] step,
                               input logic [7:0] threshold);
    write_reg(CFG_MAX_LEVEL, max_lvl);
    write_reg(CFG_BRAKE_LEVEL, brake);
    write_reg(CFG_MARK_LEVEL, mark);
    write_reg(CFG_SLOW_LOW_LEVEL, slow_low);
    write_reg(CFG_MIN_LEVEL, min_lvl);
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_DONE_THRESHOLD, threshold);
    write_reg(CFG_UNUSED_IDX, 8'($urandom));
    cfg_we  <= 1'b0;
    cur_max = max_lvl;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it    = in_item_t'($urandom);
    it.op = ($urandom_range(0, 9) < 4) ? OP_SET : OP_TICK;
    if (it.op == OP_SET) begin
      it.channel = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(CHANNELS, 7))
                                                : 3'($urandom_range(0, CHANNELS - 1));
      r = $urandom_range(0, 15);
      if (r < 5)       it.program_req = PROG_RAMP;
      else if (r < 8)  it.program_req = PROG_BLINK;
      else if (r < 15) it.program_req = 3'(r - 8);
      else             it.program_req = PROG_UNDEFINED;
      r = $urandom_range(0, 9);
      if (r < 7)       it.speed = 8'($urandom_range(0, 3));
      else if (r < 9)  it.speed = 8'($urandom_range(4, 20));
      else             it.speed = 8'($urandom_range(0, 254));
      if ($urandom_range(0, 9) < 3) it.nominal = cur_max;
      it.load_level = ($urandom_range(0, 9) < 3);
    end
    return it;
  endfunction

  initial begin
    in_item_t   it;
    int         sent;
    logic [7:0] rmax;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_tick();
    send_set(3'd0, PROG_NOMINAL, 8'd0, 8'd255, 1'b0, 8'd0);
    send_set(3'd1, PROG_MAX, 8'd0, 8'd0, 1'b0, 8'd0);
    send_set(3'd2, PROG_BRAKE, 8'd0, 8'd0, 1'b0, 8'd0);
    send_set(3'd3, PROG_MARKER, 8'd0, 8'd0, 1'b0, 8'd0);
    send_set(3'd4, PROG_RAMP, 8'd0, 8'd0, 1'b1, 8'd245);
    send_set(3'd5, PROG_BLINK, 8'd0, 8'd250, 1'b1, 8'd0);
    repeat (4) send_tick();
    send_set(3'd6, PROG_OFF, 8'd0, 8'd0, 1'b0, 8'd0);
    send_set(3'd7, PROG_MAX, 8'd0, 8'd0, 1'b1, 8'd255);
    send_set(3'd0, PROG_UNDEFINED, 8'd254, 8'd0, 1'b1, 8'd255);
    send_set(3'd3, PROG_OFF, 8'd254, 8'd128, 1'b1, 8'd77);
    send_set(3'd2, PROG_RAMP, 8'd1, RST_MAX_LEVEL, 1'b1, 8'd0);
    send_set(3'd1, PROG_BLINK, 8'd254, 8'd0, 1'b0, 8'd0);
    repeat (4) send_tick();
    send_set(3'd5, PROG_RAMP, 8'd2, 8'd0, 1'b0, 8'd0);
    repeat (2) send_tick();

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      rmax = 8'($urandom_range(1, 254));
      case (ph)
        0: load_settings(RST_MAX_LEVEL, RST_BRAKE_LEVEL, RST_MARK_LEVEL, RST_SLOW_LOW_LEVEL,
                         RST_MIN_LEVEL, 8'(RST_STEP_SIZE), 8'(RST_DONE_THRESHOLD));
        1: load_settings(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0);
        2: begin
          load_settings(8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd16, 8'd6);
          // saturation at the top, then at zero on the way down
          send_set(3'd4, PROG_RAMP, 8'd0, 8'd0, 1'b1, 8'd250);
          repeat (3) send_tick();
          send_set(3'd4, PROG_RAMP, 8'd0, 8'd0, 1'b1, 8'd5);
          repeat (2) send_tick();
        end
        3: load_settings(rmax, 8'($urandom), 8'($urandom), 8'($urandom_range(0, rmax)),
                         8'($urandom_range(0, rmax)), 8'hE4, 8'hFF);
        default: load_settings(rmax, 8'($urandom), 8'($urandom), 8'($urandom_range(0, rmax)),
                               8'($urandom_range(0, rmax)), 8'($urandom_range(1, 16)),
                               8'($urandom_range(0, 6)));
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        it = random_item();
        send_item(it);
        if (!(it.op == OP_SET && it.channel >= CHANNELS)) sent++;
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("led_effect_sequencer_core test passed");
    end else begin
      $display("led_effect_sequencer_core test failed");
    end
    $finish;
  end

endmodule
